FILE: src/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes and the character-to-segment lookup for the serial
// seven-segment display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // Actions carried by an input transaction.
  localparam logic [1:0] ACT_WRITE_CHAR = 2'd0;
  localparam logic [1:0] ACT_SET_COLON  = 2'd1;
  localparam logic [1:0] ACT_REFRESH    = 2'd2;
  localparam logic [1:0] ACT_BRIGHTNESS = 2'd3;

  // Serial symbols on the result channel.
  localparam logic [1:0] SYM_START = 2'd0;
  localparam logic [1:0] SYM_BIT   = 2'd1;
  localparam logic [1:0] SYM_ACK   = 2'd2;
  localparam logic [1:0] SYM_STOP  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DATA_CMD    = 2'd0;
  localparam logic [1:0] CFG_ADDR_CMD    = 2'd1;
  localparam logic [1:0] CFG_DISPLAY_CMD = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] DATA_CMD_RESET    = 8'h40;
  localparam logic [7:0] ADDR_CMD_RESET    = 8'hC0;
  localparam logic [7:0] DISPLAY_CMD_RESET = 8'h88;

  // Frame pieces handed from the sequencer to the symbol generator.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } ssd_cmd_t;

  // Segment pattern (g..a) for a character code. Unknown codes light
  // segment a alone.
  function automatic logic [6:0] glyph_of(input logic [7:0] code);
    logic [6:0] g;
    case (code)
      8'd48:   g = 7'h3F;
      8'd49:   g = 7'h06;
      8'd50:   g = 7'h5B;
      8'd51:   g = 7'h4F;
      8'd52:   g = 7'h66;
      8'd53:   g = 7'h6D;
      8'd54:   g = 7'h7D;
      8'd55:   g = 7'h07;
      8'd56:   g = 7'h7F;
      8'd57:   g = 7'h6F;
      8'd32:   g = 7'h00;
      8'd45:   g = 7'h40;
      8'd65:   g = 7'h77;
      8'd67:   g = 7'h39;
      8'd69:   g = 7'h79;
      8'd70:   g = 7'h71;
      8'd72:   g = 7'h76;
      8'd76:   g = 7'h38;
      8'd80:   g = 7'h73;
      8'd85:   g = 7'h3E;
      8'd95:   g = 7'h08;
      8'd98:   g = 7'h7C;
      8'd99:   g = 7'h58;
      8'd100:  g = 7'h5E;
      8'd104:  g = 7'h74;
      8'd110:  g = 7'h54;
      8'd111:  g = 7'h5C;
      8'd114:  g = 7'h50;
      8'd116:  g = 7'h78;
      8'd117:  g = 7'h1C;
      8'd176:  g = 7'h63;
      default: g = 7'h01;
    endcase
    return g;
  endfunction

endpackage

FILE: src/ssd_if.sv
// ----------------------------------------------------------------------------
// ssd_if
// Valid/ready channel interfaces for the display driver's input items and
// serial symbol results.
// ----------------------------------------------------------------------------
interface ssd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] position;
  logic [7:0] char_code;
  logic       colon_on;
  logic [2:0] brightness;

  modport source (output valid, action, position, char_code, colon_on, brightness,
                  input ready);
  modport sink   (input valid, action, position, char_code, colon_on, brightness,
                  output ready);
endinterface

interface ssd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol;
  logic       line_level;
  logic       last;

  modport source (output valid, symbol, line_level, last, input ready);
  modport sink   (input valid, symbol, line_level, last, output ready);
endinterface

FILE: src/seven_segment_serial_display_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_serial_display_driver
// Segment buffer and two-wire frame sequencer for a serial seven-segment
// display.
// ----------------------------------------------------------------------------
// The block holds one segment byte per digit (dot in bit 7) and turns each
// input transaction into serial link symbols on the result channel. A
// write_char transaction updates one digit and produces no
// symbols; a position of DIGITS or more is ignored and the dot bit of the
// digit is kept. A refresh (and a set_colon, which first sets or clears the
// dot of digit 1) sends the data command frame and then the address frame
// with all digit bytes: 2 + 9 * (DIGITS + 1) + 11 symbols, 58 for four
// digits. A brightness transaction sends one frame of 11 symbols holding the
// display command base ORed with the level. Symbols leave at one per cycle
// while the result channel is ready; that pace is set by the symbol
// generator, which shifts each byte out one bit a cycle. A new input
// transaction is taken once the sequencer has handed its last frame piece
// to the generator, so it overlaps the final stop symbol of the previous one.
// Configuration registers must be written only while the block is idle.
// ----------------------------------------------------------------------------
module seven_segment_serial_display_driver
  import ssd_pkg::*;
#(
  parameter int DIGITS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  ssd_in_if.sink     in_ch,
  ssd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int STEP_W = $clog2(DIGITS + 6);

  // Frame pieces of a refresh, in order. The digit bytes start at STEP_DIGIT0
  // and the closing stop comes after the last digit.
  localparam logic [STEP_W-1:0] STEP_OPEN       = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_DATA_CMD   = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_DATA_STOP  = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_ADDR_START = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_ADDR_CMD   = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_DIGIT0     = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_LAST_REF   = STEP_W'(DIGITS + 5);
  localparam logic [STEP_W-1:0] STEP_LAST_BRT   = STEP_W'(2);

  localparam logic MODE_REFRESH = 1'b0;
  localparam logic MODE_BRIGHT  = 1'b1;

  // Configuration registers.
  logic [7:0] dcmd_r, acmd_r, dbase_r;

  // Display buffer: segments g..a and the dot bit kept apart, so that a
  // character write never has to read the digit it replaces.
  logic [6:0] seg_r [DIGITS];
  logic       dot_r [DIGITS];

  // Sequencer state.
  logic              busy_r;
  logic              mode_r;
  logic [STEP_W-1:0] step_r;
  logic [7:0]        bright_r;

  logic              in_acc;
  logic              cmd_valid;
  logic              cmd_ready;
  ssd_cmd_t          cmd;
  logic [STEP_W-1:0] last_step;
  logic [STEP_W-1:0] byte_off;
  logic [IDX_W-1:0]  byte_idx;
  logic [7:0]        buf_byte;
  logic [IDX_W-1:0]  wr_idx;

  assign in_ch.ready = !busy_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wr_idx      = in_ch.position[IDX_W-1:0];

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcmd_r  <= DATA_CMD_RESET;
      acmd_r  <= ADDR_CMD_RESET;
      dbase_r <= DISPLAY_CMD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DATA_CMD:    dcmd_r  <= cfg_data;
        CFG_ADDR_CMD:    acmd_r  <= cfg_data;
        CFG_DISPLAY_CMD: dbase_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the frame piece for the current step. A brightness frame is just
  // start, one byte and stop; a refresh walks the whole list.
  assign last_step = (mode_r == MODE_BRIGHT) ? STEP_LAST_BRT : STEP_LAST_REF;
  assign byte_off  = step_r - STEP_DIGIT0;
  assign byte_idx  = byte_off[IDX_W-1:0];
  assign buf_byte  = {dot_r[byte_idx], seg_r[byte_idx]};
  assign cmd_valid = busy_r;

  always_comb begin
    cmd.last = (step_r == last_step);
    if (step_r == STEP_OPEN) begin
      cmd.kind = CMD_START;
    end else if (step_r == last_step ||
                 (mode_r == MODE_REFRESH && step_r == STEP_DATA_STOP)) begin
      cmd.kind = CMD_STOP;
    end else if (mode_r == MODE_REFRESH && step_r == STEP_ADDR_START) begin
      cmd.kind = CMD_START;
    end else begin
      cmd.kind = CMD_BYTE;
    end
    if (mode_r == MODE_BRIGHT) begin
      cmd.data = bright_r;
    end else if (step_r == STEP_DATA_CMD) begin
      cmd.data = dcmd_r;
    end else if (step_r == STEP_ADDR_CMD) begin
      cmd.data = acmd_r;
    end else begin
      cmd.data = buf_byte;
    end
  end

  // Buffer updates and sequencer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mode_r <= MODE_REFRESH;
      step_r <= STEP_OPEN;
      for (int k = 0; k < DIGITS; k++) begin
        seg_r[k] <= 7'd0;
        dot_r[k] <= 1'b0;
      end
    end else if (in_acc) begin
      case (in_ch.action)
        ACT_WRITE_CHAR: begin
          if (in_ch.position < 3'(DIGITS)) begin
            seg_r[wr_idx] <= glyph_of(in_ch.char_code);
          end
        end
        ACT_SET_COLON: begin
          // A single-digit display has no digit 1, so only the refresh runs.
          if (DIGITS >= 2) begin
            dot_r[IDX_W'(1 % DIGITS)] <= in_ch.colon_on;
          end
          busy_r <= 1'b1;
          mode_r <= MODE_REFRESH;
          step_r <= STEP_OPEN;
        end
        ACT_REFRESH: begin
          busy_r <= 1'b1;
          mode_r <= MODE_REFRESH;
          step_r <= STEP_OPEN;
        end
        default: begin
          busy_r <= 1'b1;
          mode_r <= MODE_BRIGHT;
          step_r <= STEP_OPEN;
        end
      endcase
    end else if (cmd_valid && cmd_ready) begin
      if (step_r == last_step) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  // The brightness byte is latched at acceptance.
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.action == ACT_BRIGHTNESS) begin
      bright_r <= dbase_r | {5'd0, in_ch.brightness};
    end
  end

  ssd_sym_gen u_sym_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .out_ch    (out_ch)
  );

  // Any transaction other than a character write starts a frame sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
                   in_acc && in_ch.action != ACT_WRITE_CHAR |=> busy_r && step_r == STEP_OPEN)
    else $error("sequencer did not start a frame sequence");

  // A character write never starts the sequencer.
  assert property (@(posedge clk) disable iff (!rst_n)
                   in_acc && in_ch.action == ACT_WRITE_CHAR |=> !busy_r)
    else $error("character write started the sequencer");

  // The step counter stays within the current frame list.
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> step_r <= last_step)
    else $error("sequencer step ran past the last frame piece");

endmodule

FILE: src/ssd_sym_gen.sv
// ----------------------------------------------------------------------------
// ssd_sym_gen
// Turns frame pieces (start, byte, stop) into serial symbols, one per cycle
// while the output is ready, shifting bytes out LSB first via a shift register.
// ----------------------------------------------------------------------------
module ssd_sym_gen
  import ssd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  ssd_cmd_t         cmd,
  output logic             cmd_ready,
  ssd_out_if.source        out_ch
);

  logic       busy_r, busy_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       blast_r, blast_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [1:0] osym_r, osym_nxt;
  logic       olevel_r, olevel_nxt;
  logic       olast_r, olast_nxt;
  logic       adv;

  assign adv       = !ovalid_r || out_ch.ready;
  assign cmd_ready = !busy_r && adv;

  always_comb begin
    busy_nxt   = busy_r;
    shift_nxt  = shift_r;
    cnt_nxt    = cnt_r;
    blast_nxt  = blast_r;
    ovalid_nxt = ovalid_r;
    osym_nxt   = osym_r;
    olevel_nxt = olevel_r;
    olast_nxt  = olast_r;
    if (adv) begin
      ovalid_nxt = 1'b0;
      if (busy_r) begin
        ovalid_nxt = 1'b1;
        if (cnt_r == 4'd8) begin
          // All eight bits are out; release the line for the ack slot.
          osym_nxt   = SYM_ACK;
          olevel_nxt = 1'b1;
          olast_nxt  = blast_r;
          busy_nxt   = 1'b0;
        end else begin
          osym_nxt   = SYM_BIT;
          olevel_nxt = shift_r[0];
          olast_nxt  = 1'b0;
          shift_nxt  = {1'b0, shift_r[7:1]};
          cnt_nxt    = cnt_r + 4'd1;
        end
      end else if (cmd_valid) begin
        case (cmd.kind)
          CMD_BYTE: begin
            ovalid_nxt = 1'b1;
            osym_nxt   = SYM_BIT;
            olevel_nxt = cmd.data[0];
            olast_nxt  = 1'b0;
            shift_nxt  = {1'b0, cmd.data[7:1]};
            cnt_nxt    = 4'd1;
            busy_nxt   = 1'b1;
            blast_nxt  = cmd.last;
          end
          CMD_START: begin
            ovalid_nxt = 1'b1;
            osym_nxt   = SYM_START;
            olevel_nxt = 1'b0;
            olast_nxt  = cmd.last;
          end
          CMD_STOP: begin
            ovalid_nxt = 1'b1;
            osym_nxt   = SYM_STOP;
            olevel_nxt = 1'b0;
            olast_nxt  = cmd.last;
          end
          default: begin
            ovalid_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      cnt_r    <= 4'd0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r  <= shift_nxt;
    blast_r  <= blast_nxt;
    osym_r   <= osym_nxt;
    olevel_r <= olevel_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_ch.valid      = ovalid_r;
  assign out_ch.symbol     = osym_r;
  assign out_ch.line_level = olevel_r;
  assign out_ch.last       = olast_r;

  // The bit counter never runs past the ack slot.
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r <= 4'd8)
    else $error("ssd_sym_gen: bit counter overran");

  // The closing flag only marks a stop symbol or an ack slot.
  assert property (@(posedge clk) disable iff (!rst_n)
                   ovalid_r && olast_r |-> osym_r == SYM_STOP || osym_r == SYM_ACK)
    else $error("ssd_sym_gen: last flag on a data or start symbol");

  // A symbol that waits for the receiver stays on the channel unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
                   ovalid_r && !out_ch.ready |=>
                   ovalid_r && $stable(osym_r) && $stable(olevel_r) && $stable(olast_r))
    else $error("ssd_sym_gen: stalled symbol changed");

endmodule
